// ----- sv/mbdec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdec_pkg
// Shared types, codes and sizes for the button debounce and edge counter.
// ----------------------------------------------------------------------------
package mbdec_pkg;

    // Number of debounced buttons (1..16); the button word is always 16 wide
    localparam int BUTTONS    = 16;
    localparam int WORD_W     = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int SEL_W      = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 80;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODES = 1'b1;

    // Reset value of the count mode register: every button counts presses
    localparam logic [CFG_DATA_W-1:0] COUNT_MODES_RESET = 32'h5555_5555;

    // Edge count modes
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FALL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RISE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // Per-item control shared by all button lanes
    typedef struct packed {
        logic              fire;    // item is processed this cycle
        logic              sample;  // item is a sample (not a clear)
        logic [TIME_W-1:0] now;     // item time stamp
    } mbdec_lane_ctrl_t;

    // Post-item view of one button lane
    typedef struct packed {
        logic               steady;
        logic               prev;
        logic [COUNT_W-1:0] count;
    } mbdec_lane_stat_t;

endpackage

// ----- sv/mbdec_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdec_cfg_regs
// Configuration registers: debounce time and per-button count modes.
// ----------------------------------------------------------------------------
module mbdec_cfg_regs
    import mbdec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [TIME_W-1:0]     debounce_ms,
    output logic [CFG_DATA_W-1:0] count_modes
);

    logic [TIME_W-1:0]     debounce_ms_reg;
    logic [CFG_DATA_W-1:0] count_modes_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg <= '0;
            count_modes_reg <= COUNT_MODES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS: debounce_ms_reg <= cfg_data;
                CFG_COUNT_MODES: count_modes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign debounce_ms = debounce_ms_reg;
    assign count_modes = count_modes_reg;

endmodule

// ----- sv/mbdec_button_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdec_button_lane
// One button: raw change stamp, steady level tracking and edge counter.
// ----------------------------------------------------------------------------
module mbdec_button_lane
    import mbdec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              raw,
    input  mbdec_lane_ctrl_t  ctrl,
    input  logic              clear_hit,
    input  logic [TIME_W-1:0] debounce_ms,
    input  logic [MODE_W-1:0] mode,
    output mbdec_lane_stat_t  stat
);

    logic               raw_last_reg, raw_last_next;
    logic               prev_reg, prev_next;
    logic               steady_reg, steady_next;
    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               changed;
    logic [TIME_W-1:0]  elapsed;
    logic               settled;
    logic               count_hit;

    // Raw change detection and elapsed time since the last change
    assign changed = (raw != raw_last_reg);
    assign elapsed = ctrl.now - (changed ? ctrl.now : stamp_reg);
    assign settled = (elapsed >= debounce_ms);

    // Next state
    always_comb begin
        raw_last_next = raw_last_reg;
        stamp_next    = stamp_reg;
        prev_next     = prev_reg;
        steady_next   = steady_reg;
        count_next    = count_reg;
        count_hit     = 1'b0;
        if (ctrl.sample) begin
            if (changed) begin
                raw_last_next = raw;
                stamp_next    = ctrl.now;
            end
            if (settled) begin
                prev_next   = steady_reg;
                steady_next = raw;
            end
            // Edge still showing: count it by mode, prev high means a press
            if (prev_next != steady_next) begin
                case (mode)
                    MODE_BOTH: count_hit = 1'b1;
                    MODE_FALL: count_hit = prev_next;
                    MODE_RISE: count_hit = !prev_next;
                    default:   count_hit = 1'b0;
                endcase
            end
            if (count_hit) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end else if (clear_hit) begin
            count_next = '0;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_last_reg <= 1'b1;
            prev_reg     <= 1'b1;
            steady_reg   <= 1'b1;
            stamp_reg    <= '0;
            count_reg    <= '0;
        end else if (ctrl.fire) begin
            raw_last_reg <= raw_last_next;
            prev_reg     <= prev_next;
            steady_reg   <= steady_next;
            stamp_reg    <= stamp_next;
            count_reg    <= count_next;
        end
    end

    assign stat.steady = steady_next;
    assign stat.prev   = prev_next;
    assign stat.count  = count_next;

endmodule

// ----- sv/multi_button_debounce_edge_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_counter
// Debounces a 16-bit button word by per-button change stamps and counts
// steady edges per button; reports levels, press/release masks and a count.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tdata: gpio_word, now_ms, button_index
//                                     tuser: kind
//  m_*       out   m_tvalid/m_tready  tdata: steady_levels, pressed_mask,
//                                     released_mask, selected_count
//  cfg_*     in    cfg_valid/ready    cfg_index, cfg_data (always ready)
//
//  One word per cycle sustained while results are taken; each word passes
//  the input register, then the result register, before it shows on
//  m_tvalid. All lanes work in parallel in one pass, so the next word
//  sees this one's state. Reset (aresetn low, synchronous) returns all
//  buttons to released and clears stamps, counters and the valid flags of
//  both registers. A stalled result holds the pipeline; s_tready stays
//  high while the input register can drain.
// ----------------------------------------------------------------------------
module multi_button_debounce_edge_counter
    import mbdec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input: [15:0] gpio_word, [47:16] now_ms, [51:48] button_index, zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // input: [0] kind
    input  logic                  s_tuser,
    // output: [15:0] steady_levels, [31:16] pressed_mask,
    // [47:32] released_mask, [79:48] selected_count
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  in_valid_reg;
    logic                  kind_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [SEL_W-1:0]      sel_reg;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                  fire;
    logic                  sel_ok;
    logic [TIME_W-1:0]     debounce_ms;
    logic [CFG_DATA_W-1:0] count_modes;
    mbdec_lane_ctrl_t      lane_ctrl;
    logic [WORD_W-1:0]     steady_vec, prev_vec;
    logic [COUNT_W-1:0]    count_arr [WORD_W];
    logic [COUNT_W-1:0]    sel_count;

    // Configuration registers
    mbdec_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .debounce_ms (debounce_ms),
        .count_modes (count_modes)
    );

    // Handshake: process when the result register is free or draining
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser;
            word_reg <= s_tdata[15:0];
            now_reg  <= s_tdata[47:16];
            sel_reg  <= s_tdata[51:48];
        end
    end

    assign sel_ok           = ({1'b0, sel_reg} < (SEL_W+1)'(BUTTONS));
    assign lane_ctrl.fire   = fire;
    assign lane_ctrl.sample = (kind_reg == KIND_SAMPLE);
    assign lane_ctrl.now    = now_reg;

    // Button lanes; buttons beyond the count stay released with no counter
    for (genvar b = 0; b < WORD_W; b++) begin : g_lane
        if (b < BUTTONS) begin : g_used
            mbdec_lane_stat_t stat;
            mbdec_button_lane u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .raw         (word_reg[b]),
                .ctrl        (lane_ctrl),
                .clear_hit   (sel_ok && (sel_reg == SEL_W'(b))),
                .debounce_ms (debounce_ms),
                .mode        (count_modes[MODE_W*b +: MODE_W]),
                .stat        (stat)
            );
            assign steady_vec[b] = stat.steady;
            assign prev_vec[b]   = stat.prev;
            assign count_arr[b]  = stat.count;
        end else begin : g_unused
            assign steady_vec[b] = 1'b1;
            assign prev_vec[b]   = 1'b1;
            assign count_arr[b]  = '0;
        end
    end

    // Result word
    assign sel_count = sel_ok ? count_arr[sel_reg] : '0;

    always_comb begin
        out_data_next        = '0;
        out_data_next[15:0]  = steady_vec;
        out_data_next[31:16] = prev_vec & ~steady_vec;
        out_data_next[47:32] = ~prev_vec & steady_vec;
        out_data_next[79:48] = sel_count;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/mbdec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdec_checker
// Port-level checks on the debounce edge counter's result stream.
// ----------------------------------------------------------------------------
module mbdec_checker
    import mbdec_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A button cannot be pressed and released at once
    a_mask_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] & m_tdata[47:32]) == 16'h0000)
        else $error("pressed and released masks overlap");

    // Masks agree with the steady levels they report
    a_mask_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[31:16] & m_tdata[15:0]) == 16'h0000) &&
                     ((m_tdata[47:32] & ~m_tdata[15:0]) == 16'h0000))
        else $error("mask disagrees with steady level");

endmodule

bind multi_button_debounce_edge_counter mbdec_checker u_mbdec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
